### src/stepped_fan_speed_controller_macros.svh
// Assertion macros shared by the fan controller RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef STEPPED_FAN_SPEED_CONTROLLER_MACROS_SVH
`define STEPPED_FAN_SPEED_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
`define SFC_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("fan controller check failed");
`define SFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fan controller sequence check failed");
`else
`define SFC_ASSERT(lbl, cond)
`define SFC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### src/sfc_pkg.sv
// Package for the stepped fan speed controller: widths, codes, reset values
// and the command and status structs between controller and datapath.
`timescale 1ns / 1ps

package sfc_pkg;

  localparam int MAX_STEPS  = 60;
  localparam int STEP_W     = 6;
  localparam int TEMP_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int DIV_STEPS  = TEMP_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Register reset values.
  localparam logic [STEP_W-1:0] RST_NUM_STEPS  = 6'd4;
  localparam logic [TEMP_W-1:0] RST_FULL_SCALE = 8'd60;
  localparam logic [TEMP_W-1:0] RST_COLD_LIMIT = 8'd15;
  localparam logic [TEMP_W-1:0] RST_HOT_LIMIT  = 8'd40;
  localparam logic [TEMP_W-1:0] RST_BLINK_LOW  = 8'd20;
  localparam logic [TEMP_W-1:0] RST_BLINK_HIGH = 8'd35;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_STEPS  = 3'd0,
    CFG_FULL_SCALE = 3'd1,
    CFG_COLD_LIMIT = 3'd2,
    CFG_HOT_LIMIT  = 3'd3,
    CFG_BLINK_LOW  = 3'd4,
    CFG_BLINK_HIGH = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    ZONE_NORMAL = 2'd0,
    ZONE_COLD   = 2'd1,
    ZONE_HOT    = 2'd2
  } zone_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_DIVW = 2'd1,
    S_DIVL = 2'd2,
    S_EMIT = 2'd3
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_sample;
    logic take_tick;
    logic start_lvl;
    logic resolve;
    logic pop;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic last_one;
  } sts_t;

endpackage

### src/sfc_if.sv
// Channel interfaces of the fan controller: input words, result words and
// configuration writes. Depends on sfc_pkg for field widths.
`timescale 1ns / 1ps

interface sfc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [sfc_pkg::TEMP_W-1:0]  temperature;

  modport source (output valid, op, temperature, input ready);
  modport sink (input valid, op, temperature, output ready);
endinterface

interface sfc_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  step_dir;
  logic [sfc_pkg::STEP_W-1:0]  fan_level;
  logic [1:0]                  led_zone;
  logic                        blink_led;
  logic                        last;

  modport source (output valid, step_dir, fan_level, led_zone, blink_led, last,
                  input ready);
  modport sink (input valid, step_dir, fan_level, led_zone, blink_led, last,
                output ready);
endinterface

interface sfc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sfc_pkg::CFG_IDX_W-1:0]   index;
  logic [sfc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/stepped_fan_speed_controller.sv
// Top level of the stepped fan speed controller: joins controller and
// datapath to the channel interfaces. Depends on sfc_pkg, sfc_if, sfc_ctrl, sfc_dp.
//
//   channel  role    payload
//   in_if    sink    op, temperature
//   out_if   source  step_dir, fan_level, led_zone, blink_led, last
//   cfg_if   sink    index, data (always ready)
//
// A tick gives its single result in the cycle after it is accepted.
// A sample runs two divisions on the shared divider (band width, then level)
// before its first result appears; its results then leave one per cycle while
// out_ready is high, up to 60 of them.
// A new word is accepted only once the last result of the previous one is taken.
// rst_n is synchronous; it restores the register defaults and clears the fan state.
`timescale 1ns / 1ps

module stepped_fan_speed_controller (
  input  logic       clk,
  input  logic       rst_n,
  sfc_in_if.sink     in_if,
  sfc_out_if.source  out_if,
  sfc_cfg_if.sink    cfg_if
);

  sfc_pkg::cmd_t cmd;
  sfc_pkg::sts_t sts;

  assign cfg_if.ready = 1'b1;

  sfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_op     (in_if.op),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sfc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_if.valid),
    .cfg_index      (cfg_if.index),
    .cfg_data       (cfg_if.data),
    .in_temperature (in_if.temperature),
    .step_dir       (out_if.step_dir),
    .fan_level      (out_if.fan_level),
    .led_zone       (out_if.led_zone),
    .blink_led      (out_if.blink_led),
    .last           (out_if.last)
  );

endmodule

### src/sfc_div.sv
// Restoring divider, one quotient bit per cycle, for the fan controller.
// Depends on sfc_pkg for widths and the step count.
`timescale 1ns / 1ps

module sfc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sfc_pkg::TEMP_W-1:0] dividend,
  input  logic [sfc_pkg::TEMP_W-1:0] divisor,
  output logic [sfc_pkg::TEMP_W-1:0] quotient,
  output logic                       done
);

  logic [sfc_pkg::TEMP_W-1:0]    rem_r, rem_nxt;
  logic [sfc_pkg::TEMP_W-1:0]    quo_r, quo_nxt;
  logic [sfc_pkg::TEMP_W-1:0]    dsr_r;
  logic [sfc_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic [sfc_pkg::TEMP_W:0]      trial;
  logic [sfc_pkg::TEMP_W:0]      trial_sub;
  logic                          fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial     = {rem_r, quo_r[sfc_pkg::TEMP_W-1]};
    trial_sub = trial - {1'b0, dsr_r};
    fits      = (trial >= {1'b0, dsr_r});
    rem_nxt   = fits ? trial_sub[sfc_pkg::TEMP_W-1:0] : trial[sfc_pkg::TEMP_W-1:0];
    quo_nxt   = {quo_r[sfc_pkg::TEMP_W-2:0], fits};
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == sfc_pkg::DIV_CNT_W'(sfc_pkg::DIV_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Partial remainder and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

### src/sfc_dp.sv
// Datapath of the fan controller: configuration registers, fan state,
// the shared divider and the result counter. Depends on sfc_pkg, sfc_div.
`timescale 1ns / 1ps
`include "stepped_fan_speed_controller_macros.svh"

module sfc_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sfc_pkg::cmd_t                  cmd,
  output sfc_pkg::sts_t                  sts,
  input  logic                           cfg_we,
  input  logic [sfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [sfc_pkg::TEMP_W-1:0]     in_temperature,
  output logic [1:0]                     step_dir,
  output logic [sfc_pkg::STEP_W-1:0]     fan_level,
  output logic [1:0]                     led_zone,
  output logic                           blink_led,
  output logic                           last
);

  logic [sfc_pkg::STEP_W-1:0] num_steps_r;
  logic [sfc_pkg::TEMP_W-1:0] full_scale_r;
  logic [sfc_pkg::TEMP_W-1:0] cold_limit_r;
  logic [sfc_pkg::TEMP_W-1:0] hot_limit_r;
  logic [sfc_pkg::TEMP_W-1:0] blink_low_r;
  logic [sfc_pkg::TEMP_W-1:0] blink_high_r;

  logic [sfc_pkg::STEP_W-1:0] fan_level_r, fan_level_nxt;
  logic [sfc_pkg::TEMP_W-1:0] last_temp_r;
  logic                       blink_r;
  sfc_pkg::zone_t             zone_r, zone_nxt;
  logic [sfc_pkg::TEMP_W-1:0] w_r;
  sfc_pkg::dir_t              dir_r, dir_nxt;
  logic [sfc_pkg::STEP_W-1:0] cnt_r, cnt_nxt;

  logic [sfc_pkg::STEP_W-1:0] n_eff;
  logic                       div_start;
  logic [sfc_pkg::TEMP_W-1:0] div_dividend;
  logic [sfc_pkg::TEMP_W-1:0] div_divisor;
  logic [sfc_pkg::TEMP_W-1:0] div_q;
  logic                       div_done;
  logic [sfc_pkg::STEP_W-1:0] diff;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_steps_r  <= sfc_pkg::RST_NUM_STEPS;
      full_scale_r <= sfc_pkg::RST_FULL_SCALE;
      cold_limit_r <= sfc_pkg::RST_COLD_LIMIT;
      hot_limit_r  <= sfc_pkg::RST_HOT_LIMIT;
      blink_low_r  <= sfc_pkg::RST_BLINK_LOW;
      blink_high_r <= sfc_pkg::RST_BLINK_HIGH;
    end else if (cfg_we) begin
      case (cfg_index)
        sfc_pkg::CFG_NUM_STEPS:  num_steps_r  <= cfg_data[sfc_pkg::STEP_W-1:0];
        sfc_pkg::CFG_FULL_SCALE: full_scale_r <= cfg_data;
        sfc_pkg::CFG_COLD_LIMIT: cold_limit_r <= cfg_data;
        sfc_pkg::CFG_HOT_LIMIT:  hot_limit_r  <= cfg_data;
        sfc_pkg::CFG_BLINK_LOW:  blink_low_r  <= cfg_data;
        sfc_pkg::CFG_BLINK_HIGH: blink_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective step count: zero counts as one, large values saturate.
  always_comb begin
    if (num_steps_r == '0) begin
      n_eff = sfc_pkg::STEP_W'(1);
    end else if (num_steps_r > sfc_pkg::STEP_W'(sfc_pkg::MAX_STEPS)) begin
      n_eff = sfc_pkg::STEP_W'(sfc_pkg::MAX_STEPS);
    end else begin
      n_eff = num_steps_r;
    end
  end

  // The divider first finds the band width, then the level within it.
  assign div_start    = cmd.take_sample | cmd.start_lvl;
  assign div_dividend = cmd.take_sample ? full_scale_r : last_temp_r;
  assign div_divisor  = cmd.take_sample ? {2'b00, n_eff} : div_q;

  sfc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .done     (div_done)
  );

  // Zone of a new sample.
  always_comb begin
    if (in_temperature < cold_limit_r) begin
      zone_nxt = sfc_pkg::ZONE_COLD;
    end else if (in_temperature > hot_limit_r) begin
      zone_nxt = sfc_pkg::ZONE_HOT;
    end else begin
      zone_nxt = sfc_pkg::ZONE_NORMAL;
    end
  end

  // Target level and the pulse count toward it.
  always_comb begin
    if (last_temp_r == '0) begin
      fan_level_nxt = '0;
    end else if (last_temp_r >= full_scale_r) begin
      fan_level_nxt = n_eff;
    end else if (w_r == '0) begin
      fan_level_nxt = n_eff - 1'b1;
    end else if (div_q > {2'b00, n_eff - 1'b1}) begin
      fan_level_nxt = n_eff - 1'b1;
    end else begin
      fan_level_nxt = div_q[sfc_pkg::STEP_W-1:0];
    end

    if (fan_level_nxt > fan_level_r) begin
      diff    = fan_level_nxt - fan_level_r;
      dir_nxt = sfc_pkg::DIR_UP;
    end else begin
      diff    = fan_level_r - fan_level_nxt;
      dir_nxt = sfc_pkg::DIR_DOWN;
    end

    if (diff == '0) begin
      cnt_nxt = sfc_pkg::STEP_W'(1);
      dir_nxt = sfc_pkg::DIR_NONE;
    end else begin
      cnt_nxt = diff;
    end
  end

  // Fan state and the result counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fan_level_r <= '0;
      last_temp_r <= '0;
      blink_r     <= 1'b0;
      zone_r      <= sfc_pkg::ZONE_NORMAL;
      dir_r       <= sfc_pkg::DIR_NONE;
      cnt_r       <= '0;
    end else begin
      if (cmd.take_sample) begin
        last_temp_r <= in_temperature;
        zone_r      <= zone_nxt;
      end
      if (cmd.take_tick) begin
        if ((last_temp_r < blink_low_r) || (last_temp_r > blink_high_r)) begin
          blink_r <= ~blink_r;
        end
        dir_r <= sfc_pkg::DIR_NONE;
        cnt_r <= sfc_pkg::STEP_W'(1);
      end
      if (cmd.resolve) begin
        fan_level_r <= fan_level_nxt;
        dir_r       <= dir_nxt;
        cnt_r       <= cnt_nxt;
      end
      if (cmd.pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Band width is kept for the level step.
  always_ff @(posedge clk) begin
    if (cmd.start_lvl) begin
      w_r <= div_q;
    end
  end

  assign sts.div_done = div_done;
  assign sts.last_one = (cnt_r == sfc_pkg::STEP_W'(1));

  assign step_dir  = dir_r;
  assign fan_level = fan_level_r;
  assign led_zone  = zone_r;
  assign blink_led = blink_r;
  assign last      = (cnt_r == sfc_pkg::STEP_W'(1));

  `SFC_ASSERT(a_level_range, fan_level_r <= sfc_pkg::STEP_W'(sfc_pkg::MAX_STEPS))
  `SFC_ASSERT(a_idle_single, (dir_r != sfc_pkg::DIR_NONE) || (cnt_r <= sfc_pkg::STEP_W'(1)))
  `SFC_ASSERT_NEXT(a_pop_count, cmd.pop && !cmd.resolve && !cmd.take_tick, cnt_r == $past(cnt_r) - 1'b1)

endmodule

### src/sfc_ctrl.sv
// Controller state machine of the fan controller: sequences the two
// divisions and the result words. Depends on sfc_pkg.
`timescale 1ns / 1ps
`include "stepped_fan_speed_controller_macros.svh"

module sfc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_op,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  sfc_pkg::sts_t sts,
  output sfc_pkg::cmd_t cmd
);

  sfc_pkg::state_t state_r, state_nxt;
  logic            accept;

  assign accept = (state_r == sfc_pkg::S_IDLE) && in_valid;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sfc_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = (in_op == sfc_pkg::OP_TICK) ? sfc_pkg::S_EMIT : sfc_pkg::S_DIVW;
        end
      end
      sfc_pkg::S_DIVW: begin
        if (sts.div_done) state_nxt = sfc_pkg::S_DIVL;
      end
      sfc_pkg::S_DIVL: begin
        if (sts.div_done) state_nxt = sfc_pkg::S_EMIT;
      end
      sfc_pkg::S_EMIT: begin
        if (out_ready && sts.last_one) state_nxt = sfc_pkg::S_IDLE;
      end
      default: state_nxt = sfc_pkg::S_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    cmd             = '0;
    case (state_r)
      sfc_pkg::S_IDLE: begin
        in_ready        = 1'b1;
        cmd.take_sample = accept && (in_op == sfc_pkg::OP_SAMPLE);
        cmd.take_tick   = accept && (in_op == sfc_pkg::OP_TICK);
      end
      sfc_pkg::S_DIVW: cmd.start_lvl = sts.div_done;
      sfc_pkg::S_DIVL: cmd.resolve = sts.div_done;
      sfc_pkg::S_EMIT: begin
        out_valid = 1'b1;
        cmd.pop   = out_ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `SFC_ASSERT(a_done_in_div, !sts.div_done || (state_r == sfc_pkg::S_DIVW) || (state_r == sfc_pkg::S_DIVL))
  `SFC_ASSERT_NEXT(a_tick_emits, cmd.take_tick, (state_r == sfc_pkg::S_EMIT) && sts.last_one)
  `SFC_ASSERT_NEXT(a_sample_divides, cmd.take_sample, (state_r == sfc_pkg::S_DIVW) && !sts.div_done)

endmodule
